/* rtl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants for the UTF-8 stream decoder
// Lead byte classes, field widths and the struct that carries one
// decoded beat from the step logic to the result register.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LeftW = 2;

  localparam logic [CpW-1:0] BadLeadCp = CpW'(8'h3F);

  typedef enum logic [2:0] {
    LEAD_ONE,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           bad_lead;
    logic           cut_short;
    logic           text_done;
  } step_res_t;

  function automatic lead_class_t classify_lead(input logic [ByteW-1:0] b);
    lead_class_t c;
    priority if ((b & 8'h80) == 8'h00) c = LEAD_ONE;
    else if ((b & 8'hE0) == 8'hC0)     c = LEAD_TWO;
    else if ((b & 8'hF0) == 8'hE0)     c = LEAD_THREE;
    else if ((b & 8'hF8) == 8'hF0)     c = LEAD_FOUR;
    else                               c = LEAD_BAD;
    return c;
  endfunction

  // Pad a partial value with the zero bits of the missing continuation bytes.
  function automatic logic [CpW-1:0] pad_missing(input logic [CpW-1:0] v,
                                                  input logic [LeftW-1:0] left);
    logic [CpW-1:0] r;
    unique case (left)
      2'd0:    r = v;
      2'd1:    r = v << 6;
      2'd2:    r = v << 12;
      default: r = v << 18;
    endcase
    return r;
  endfunction

endpackage

/* rtl/u8d_in_reg.sv */
// ----------------------------------------------------------------------------
// u8d_in_reg: input register stage
// Capture one text beat and hold it until the step logic consumes it.
// ----------------------------------------------------------------------------
module u8d_in_reg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     text_valid,
  output logic                     text_stall,
  input  logic [u8d_pkg::ByteW-1:0] text_byte,
  input  logic                     end_of_text,
  input  logic                     take,
  output logic                     held_valid,
  output logic [u8d_pkg::ByteW-1:0] held_byte,
  output logic                     held_last
);
  import u8d_pkg::*;

  // Hold while a beat sits here that the step logic cannot yet consume.
  assign text_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || take) begin
      held_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      held_byte <= text_byte;
      held_last <= end_of_text;
    end
  end

endmodule

/* rtl/u8d_step.sv */
// ----------------------------------------------------------------------------
// u8d_step: single-byte decode step
// Class the byte or shift it in, and work out the next sequence state and
// the code point, if any, that this byte completes.
// ----------------------------------------------------------------------------
module u8d_step (
  input  logic [u8d_pkg::ByteW-1:0] b,
  input  logic                      last,
  input  logic [u8d_pkg::LeftW-1:0] bytes_left,
  input  logic [u8d_pkg::CpW-1:0]   partial_value,
  output logic [u8d_pkg::LeftW-1:0] bytes_left_next,
  output logic [u8d_pkg::CpW-1:0]   partial_value_next,
  output u8d_pkg::step_res_t        res
);
  import u8d_pkg::*;

  lead_class_t    cls;
  logic [CpW-1:0] shifted;
  logic [CpW-1:0] gathered;
  logic [LeftW-1:0] left_after;

  assign cls     = classify_lead(b);
  assign shifted = {partial_value[CpW-7:0], b[5:0]};

  always_comb begin
    res                = '0;
    gathered           = partial_value;
    left_after         = bytes_left;
    bytes_left_next    = bytes_left;
    partial_value_next = partial_value;

    if (bytes_left == '0) begin
      unique case (cls)
        LEAD_ONE: begin
          res.emit       = 1'b1;
          res.code_point = CpW'(b);
          res.text_done  = last;
          left_after     = '0;
        end
        LEAD_TWO: begin
          gathered   = CpW'(b & 8'h1F);
          left_after = 2'd1;
        end
        LEAD_THREE: begin
          gathered   = CpW'(b & 8'h0F);
          left_after = 2'd2;
        end
        LEAD_FOUR: begin
          gathered   = CpW'(b & 8'h07);
          left_after = 2'd3;
        end
        default: begin
          res.emit       = 1'b1;
          res.code_point = BadLeadCp;
          res.bad_lead   = 1'b1;
          res.text_done  = last;
          left_after     = '0;
        end
      endcase
    end else begin
      gathered   = shifted;
      left_after = bytes_left - 2'd1;
      if (left_after == '0) begin
        res.emit       = 1'b1;
        res.code_point = shifted;
        res.text_done  = last;
      end
    end

    if (left_after != '0) begin
      if (last) begin
        res.emit           = 1'b1;
        res.code_point     = pad_missing(gathered, left_after);
        res.cut_short      = 1'b1;
        res.text_done      = 1'b1;
        bytes_left_next    = '0;
        partial_value_next = '0;
      end else begin
        bytes_left_next    = left_after;
        partial_value_next = gathered;
      end
    end else begin
      bytes_left_next    = '0;
      partial_value_next = '0;
    end
  end

endmodule

/* rtl/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder: byte-at-a-time UTF-8 to code point decoder
// Input register, combinational decode step with sequence state, result register.
// ----------------------------------------------------------------------------
// Feed the text one byte per beat on the text channel, with end_of_text high
// on the final byte; one code point beat leaves on the cp channel for every
// completed character. The block takes a byte every cycle: each byte is
// decoded against the open-sequence state while it sits in the input
// register, and the code point it completes is loaded into the result
// register at the next edge, so a code point is offered in the cycle after its
// final byte is taken. Throughput is one byte per clock for as long as the
// result side keeps up; while a result is held off, a byte that completes a
// character waits in the input register and the text channel stalls in that
// same cycle. Continuation bytes are taken without checking their top bits,
// and overlong or surrogate forms pass through. A byte that cannot start a
// sequence yields 0x3F with bad_lead set. If the text ends inside a sequence
// the missing bits read as zero and the code point carries cut_short and
// text_done; after the final byte the sequence state is back at reset.
module utf8_stream_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      text_valid,
  output logic                      text_stall,
  input  logic [u8d_pkg::ByteW-1:0] text_byte,
  input  logic                      end_of_text,
  output logic                      cp_valid,
  input  logic                      cp_stall,
  output logic [u8d_pkg::CpW-1:0]   code_point,
  output logic                      bad_lead,
  output logic                      cut_short,
  output logic                      text_done
);
  import u8d_pkg::*;

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             held_last;
  logic             take;

  // Open-sequence state.
  logic [LeftW-1:0] bytes_left;
  logic [LeftW-1:0] bytes_left_next;
  logic [CpW-1:0]   partial_value;
  logic [CpW-1:0]   partial_value_next;

  step_res_t res;

  u8d_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .take        (take),
    .held_valid  (held_valid),
    .held_byte   (held_byte),
    .held_last   (held_last)
  );

  u8d_step u_step (
    .b                  (held_byte),
    .last               (held_last),
    .bytes_left         (bytes_left),
    .partial_value      (partial_value),
    .bytes_left_next    (bytes_left_next),
    .partial_value_next (partial_value_next),
    .res                (res)
  );

  // Consume the held beat unless it completes a character and the result
  // register is still full and stalled. Bytes mid-sequence always advance.
  assign take = held_valid && (!res.emit || !cp_valid || !cp_stall);

  // Advance the sequence state on every consumed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      partial_value <= '0;
    end else if (take) begin
      bytes_left    <= bytes_left_next;
      partial_value <= partial_value_next;
    end
  end

  // Result register: load on a completing beat, drop once delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (take && res.emit) begin
      cp_valid <= 1'b1;
    end else if (!cp_stall) begin
      cp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.emit) begin
      code_point <= res.code_point;
      bad_lead   <= res.bad_lead;
      cut_short  <= res.cut_short;
      text_done  <= res.text_done;
    end
  end

  // Partial value never holds more bits than the bytes taken so far allow.
  a_partial_width : assert property (@(posedge clk) disable iff (rst)
    (bytes_left == 2'd0 -> partial_value == '0) &&
    (bytes_left == 2'd1 -> partial_value[CpW-1:15] == '0) &&
    (bytes_left == 2'd2 -> partial_value[CpW-1:9] == '0) &&
    (bytes_left == 2'd3 -> partial_value[CpW-1:3] == '0))
    else $error("partial value wider than the gathered bits");

  // A consumed final byte always closes the sequence.
  a_end_closes : assert property (@(posedge clk) disable iff (rst)
    take && held_last |=> bytes_left == '0 && partial_value == '0)
    else $error("sequence left open after the final byte");

  // A bad lead beat carries the replacement value and no cut-short flag.
  a_bad_lead : assert property (@(posedge clk) disable iff (rst)
    cp_valid && bad_lead |-> code_point == BadLeadCp && !cut_short)
    else $error("bad lead beat malformed");

  // A cut-short beat is always the last of its text.
  a_cut_done : assert property (@(posedge clk) disable iff (rst)
    cp_valid && cut_short |-> text_done && !bad_lead)
    else $error("cut-short beat not marked as end of text");

endmodule
